// ===== design/psve_pkg.sv =====
// Package for the polyphonic sine voice engine.
// Holds the voice stage and sequencer state types, message kinds,
// register indexes and the constant pitch and level tables. No dependencies.
`timescale 1ns / 1ps

package psve_pkg;

  typedef enum logic [1:0] {
    STAGE_OFF,
    STAGE_ATTACK,
    STAGE_SUSTAIN,
    STAGE_RELEASE
  } stage_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ON_SCAN,
    ST_ON_CLAIM,
    ST_OFF_SCAN,
    ST_T_LOAD,
    ST_T_ENV,
    ST_T_MUL1,
    ST_T_MUL2,
    ST_T_ACC,
    ST_T_DONE
  } seq_state_t;

  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;

  localparam logic [1:0] REG_ATTACK_STEP    = 2'd0;
  localparam logic [1:0] REG_RELEASE_FACTOR = 2'd1;
  localparam logic [1:0] REG_RELEASE_FLOOR  = 2'd2;

  localparam logic [23:0] ATTACK_STEP_RST    = 24'd87381;
  localparam logic [23:0] RELEASE_FACTOR_RST = 24'd16771392;
  localparam logic [23:0] RELEASE_FLOOR_RST  = 24'd839;
  localparam logic [23:0] ENV_ONE            = 24'd8388608;

  localparam int unsigned LEVEL_W = 13;
  localparam int unsigned SUM_W   = 40;
  localparam int unsigned PROD_W  = 30;

  typedef logic [31:0] octave_rom_t [12];
  localparam octave_rom_t OCTAVE5_HZ_Q16 = '{
    32'd17145893, 32'd18165441, 32'd19245614, 32'd20390018,
    32'd21602472, 32'd22887021, 32'd24247954, 32'd25689813,
    32'd27217409, 32'd28835840, 32'd30550508, 32'd32367136
  };

  typedef logic [LEVEL_W-1:0] level_rom_t [128];

  function automatic level_rom_t build_level_rom();
    level_rom_t rom;
    logic [31:0] v;
    for (int i = 0; i < 128; i++) begin
      v = (32'(i) * 32'd786432 + 32'd6350) / 32'd12700;
      rom[i] = v[LEVEL_W-1:0];
    end
    return rom;
  endfunction

  localparam level_rom_t LEVEL_ROM = build_level_rom();

endpackage

// ===== design/polyphonic_sine_voice_engine.sv =====
// Top level of the polyphonic sine voice engine: voice state, sequencer and
// the shared envelope and mixing datapath. Depends on psve_pkg.
`timescale 1ns / 1ps

// Input beats carry either a MIDI message (command = 0) or one sample tick
// (command = 1). Only a tick produces an output beat: the mixed Q1.15 sample,
// the voices active at the start of the tick and the saturating steal count.
// The block takes one input beat at a time and holds in_stall high while it
// works on it. A note-on scans all voices, one per cycle, then claims one.
// A note-off scans all voices. A tick walks the voices through one envelope
// unit and one multiplier chain: an off voice is only loaded, a sounding
// voice goes through load, envelope, first multiply, second multiply and
// accumulate (or only load and envelope when it turns off in release), and
// then the sample is formed. The result sits in an output register; if it
// has not been taken when the next tick ends, the block waits there with
// in_stall high. Reset turns every voice off, clears the counters and
// restores the register defaults. Registers lie at byte addresses 0, 4 and
// 8 of the APB port and read back their 24-bit values.
module polyphonic_sine_voice_engine #(
  parameter int VOICES          = 8,
  parameter int SAMPLE_RATE_HZ  = 48000,
  parameter int SINE_TABLE_BITS = 10,
  parameter int PHASE_BITS      = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [7:0]  status_byte,
  input  logic [6:0]  note_number,
  input  logic [6:0]  velocity,
  input  logic [1:0]  byte_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [15:0] audio_sample,
  output logic [3:0]  active_voices,
  output logic [15:0] steal_count
);
  import psve_pkg::*;

  localparam int VW        = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SINE_SIZE = 1 << SINE_TABLE_BITS;
  localparam int QB        = SINE_TABLE_BITS - 2;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned IncDen = (PHASE_BITS >= 21) ? 64'(SAMPLE_RATE_HZ)
      : (64'(SAMPLE_RATE_HZ) << (21 - PHASE_BITS));

  typedef logic signed [15:0] sine_rom_t [SINE_SIZE];
  typedef logic [PHASE_BITS-1:0] inc_rom_t [128];

  function automatic logic [15:0] quarter_sine(input longint unsigned k);
    longint unsigned x, x2, term;
    longint sum;
    x = (k * HALF_PI_Q30) >> QB;
    x2 = (x * x) >> 30;
    sum = longint'(x);
    term = ((x * x2) >> 30) / 64'd6;
    sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum = sum - longint'(term);
    if (sum < 0) sum = 0;
    sum = (sum + 16384) >>> 15;
    if (sum > 32767) sum = 32767;
    return 16'(sum);
  endfunction

  function automatic sine_rom_t build_sine();
    sine_rom_t rom;
    longint unsigned quarter, r, q;
    logic [15:0] v;
    quarter = 64'(SINE_SIZE) >> 2;
    for (int i = 0; i < SINE_SIZE; i++) begin
      q = 64'(i) >> QB;
      r = 64'(i) & (quarter - 1);
      v = q[0] ? quarter_sine(quarter - r) : quarter_sine(r);
      rom[i] = q[1] ? -$signed(v) : $signed(v);
    end
    return rom;
  endfunction

  function automatic inc_rom_t build_inc();
    inc_rom_t rom;
    longint unsigned num;
    for (int n = 0; n < 128; n++) begin
      num = 64'(OCTAVE5_HZ_Q16[n % 12]) << (n / 12);
      if (PHASE_BITS >= 21) num = num << (PHASE_BITS - 21);
      num = (num + IncDen / 2) / IncDen;
      rom[n] = num[PHASE_BITS-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();
  localparam inc_rom_t  INC_ROM  = build_inc();

  logic [23:0] attack_step, release_factor, release_floor;

  stage_t               voice_stage    [VOICES];
  logic [6:0]           voice_note     [VOICES];
  logic [PHASE_BITS-1:0] voice_phase   [VOICES];
  logic [23:0]          voice_envelope [VOICES];
  logic [6:0]           voice_level    [VOICES];
  logic [31:0]          voice_stamp    [VOICES];
  logic [31:0]          note_counter;
  logic [15:0]          steals_total;

  seq_state_t state, state_next;
  logic [VW-1:0] vcnt;
  logic          last_voice;
  logic          found;
  logic [VW-1:0] pick_off, pick_min;
  logic [31:0]   min_stamp;
  logic [6:0]    msg_note, msg_vel;
  logic [6:0]    active_cnt;
  logic signed [SUM_W-1:0] sum;
  logic [15:0]   sine_mag;
  logic          sine_neg;
  logic [PHASE_BITS-1:0] inc_q;
  logic [LEVEL_W-1:0] lvl_q;
  logic [47:0]   rel_q;
  logic [24:0]   att_q;
  logic [23:0]   env_cur;
  logic [39:0]   p1;
  logic [PROD_W-1:0] p2;

  logic [6:0]  d1, d2;
  logic        is_on, is_off;
  logic        cfg_write;
  logic        out_free;
  logic [SUM_W-1:0] sum_mag;
  logic [SUM_W-1:0] mag;
  logic [15:0] sample_val;
  logic signed [15:0] sine_val;
  logic [52:0] p2_full;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign last_voice = (vcnt == VW'(VOICES - 1));
  assign out_free  = !out_valid || !out_stall;

  assign d1 = (byte_count > 2'd1) ? note_number : 7'd0;
  assign d2 = (byte_count > 2'd2) ? velocity : 7'd0;
  assign is_on  = (byte_count != 2'd0) && (status_byte[7:4] == KIND_NOTE_ON) && (d2 != 7'd0);
  assign is_off = (byte_count != 2'd0) && ((status_byte[7:4] == KIND_NOTE_OFF) ||
                  ((status_byte[7:4] == KIND_NOTE_ON) && (d2 == 7'd0)));

  always_comb begin
    unique case (paddr[3:2])
      REG_ATTACK_STEP:    prdata = {8'd0, attack_step};
      REG_RELEASE_FACTOR: prdata = {8'd0, release_factor};
      REG_RELEASE_FLOOR:  prdata = {8'd0, release_floor};
      default:            prdata = 32'd0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (command) state_next = ST_T_LOAD;
          else if (is_on) state_next = ST_ON_SCAN;
          else if (is_off) state_next = ST_OFF_SCAN;
        end
      end
      ST_ON_SCAN:  if (last_voice) state_next = ST_ON_CLAIM;
      ST_ON_CLAIM: state_next = ST_IDLE;
      ST_OFF_SCAN: if (last_voice) state_next = ST_IDLE;
      ST_T_LOAD: begin
        if (voice_stage[vcnt] != STAGE_OFF) state_next = ST_T_ENV;
        else if (last_voice) state_next = ST_T_DONE;
      end
      ST_T_ENV: begin
        if (voice_stage[vcnt] == STAGE_RELEASE && rel_q[47:24] < release_floor) begin
          state_next = last_voice ? ST_T_DONE : ST_T_LOAD;
        end else begin
          state_next = ST_T_MUL1;
        end
      end
      ST_T_MUL1: state_next = ST_T_MUL2;
      ST_T_MUL2: state_next = ST_T_ACC;
      ST_T_ACC:  state_next = last_voice ? ST_T_DONE : ST_T_LOAD;
      ST_T_DONE: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != ST_IDLE);
  end

  assign sine_val = SINE_ROM[voice_phase[vcnt][PHASE_BITS-1 -: SINE_TABLE_BITS]];
  assign p2_full  = p1 * lvl_q;
  assign sum_mag  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign mag      = (sum_mag + SUM_W'(32768)) >> 16;

  always_comb begin
    if (sum[SUM_W-1]) begin
      sample_val = (mag >= SUM_W'(32768)) ? 16'h8000 : 16'(-mag[15:0]);
    end else begin
      sample_val = (mag >= SUM_W'(32767)) ? 16'h7FFF : mag[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      attack_step <= ATTACK_STEP_RST;
      release_factor <= RELEASE_FACTOR_RST;
      release_floor <= RELEASE_FLOOR_RST;
      note_counter <= 32'd0;
      steals_total <= 16'd0;
      out_valid <= 1'b0;
      vcnt <= '0;
      for (int i = 0; i < VOICES; i++) voice_stage[i] <= STAGE_OFF;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (paddr[3:2])
          REG_ATTACK_STEP:    attack_step <= pwdata[23:0];
          REG_RELEASE_FACTOR: release_factor <= pwdata[23:0];
          REG_RELEASE_FLOOR:  release_floor <= pwdata[23:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: vcnt <= '0;
        ST_ON_SCAN, ST_OFF_SCAN: begin
          if (state == ST_OFF_SCAN && voice_note[vcnt] == msg_note &&
              (voice_stage[vcnt] == STAGE_ATTACK || voice_stage[vcnt] == STAGE_SUSTAIN)) begin
            voice_stage[vcnt] <= STAGE_RELEASE;
          end
          vcnt <= last_voice ? '0 : vcnt + 1'b1;
        end
        ST_ON_CLAIM: begin
          if (!found && steals_total != 16'hFFFF) steals_total <= steals_total + 16'd1;
          note_counter <= note_counter + 32'd1;
          voice_stage[found ? pick_off : pick_min] <= STAGE_ATTACK;
        end
        ST_T_LOAD: begin
          if (voice_stage[vcnt] == STAGE_OFF) begin
            vcnt <= last_voice ? '0 : vcnt + 1'b1;
          end
        end
        ST_T_ENV: begin
          if (voice_stage[vcnt] == STAGE_RELEASE && rel_q[47:24] < release_floor) begin
            voice_stage[vcnt] <= STAGE_OFF;
            vcnt <= last_voice ? '0 : vcnt + 1'b1;
          end else if (voice_stage[vcnt] == STAGE_ATTACK && att_q >= 25'(ENV_ONE)) begin
            voice_stage[vcnt] <= STAGE_SUSTAIN;
          end
        end
        ST_T_ACC: vcnt <= last_voice ? '0 : vcnt + 1'b1;
        ST_T_DONE: if (out_free) out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        msg_note <= d1;
        msg_vel <= d2;
        found <= 1'b0;
        active_cnt <= 7'd0;
        sum <= '0;
      end
      ST_ON_SCAN: begin
        if (!found && voice_stage[vcnt] == STAGE_OFF) begin
          found <= 1'b1;
          pick_off <= vcnt;
        end
        if (vcnt == '0 || voice_stamp[vcnt] < min_stamp) begin
          min_stamp <= voice_stamp[vcnt];
          pick_min <= vcnt;
        end
      end
      ST_ON_CLAIM: begin
        voice_note[found ? pick_off : pick_min] <= msg_note;
        voice_stamp[found ? pick_off : pick_min] <= note_counter + 32'd1;
        voice_phase[found ? pick_off : pick_min] <= '0;
        voice_envelope[found ? pick_off : pick_min] <= 24'd0;
        voice_level[found ? pick_off : pick_min] <= msg_vel;
      end
      ST_T_LOAD: begin
        if (voice_stage[vcnt] != STAGE_OFF) begin
          active_cnt <= active_cnt + 7'd1;
          sine_neg <= sine_val[15];
          sine_mag <= sine_val[15] ? 16'(-sine_val) : 16'(sine_val);
          inc_q <= INC_ROM[voice_note[vcnt]];
          lvl_q <= LEVEL_ROM[voice_level[vcnt]];
          rel_q <= voice_envelope[vcnt] * release_factor;
          att_q <= {1'b0, voice_envelope[vcnt]} + {1'b0, attack_step};
        end
      end
      ST_T_ENV: begin
        unique case (voice_stage[vcnt])
          STAGE_ATTACK: begin
            env_cur <= (att_q >= 25'(ENV_ONE)) ? ENV_ONE : att_q[23:0];
            voice_envelope[vcnt] <= (att_q >= 25'(ENV_ONE)) ? ENV_ONE : att_q[23:0];
          end
          STAGE_RELEASE: begin
            env_cur <= rel_q[47:24];
            voice_envelope[vcnt] <= rel_q[47:24];
          end
          default: env_cur <= voice_envelope[vcnt];
        endcase
      end
      ST_T_MUL1: begin
        p1 <= sine_mag * env_cur;
        voice_phase[vcnt] <= voice_phase[vcnt] + inc_q;
      end
      ST_T_MUL2: p2 <= PROD_W'(p2_full >> 23);
      ST_T_ACC: begin
        if (sine_neg) sum <= sum - SUM_W'(p2);
        else sum <= sum + SUM_W'(p2);
      end
      ST_T_DONE: begin
        if (out_free) begin
          audio_sample <= sample_val;
          active_voices <= (active_cnt > 7'd15) ? 4'd15 : active_cnt[3:0];
          steal_count <= steals_total;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== test/psve_checker.sv =====
// Checker for the polyphonic sine voice engine: watches the input and output
// channels and the register port, predicts each sample and compares it.
// Depends on psve_pkg.
`timescale 1ns / 1ps

module psve_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        command,
  input  logic [7:0]  status_byte,
  input  logic [6:0]  note_number,
  input  logic [6:0]  velocity,
  input  logic [1:0]  byte_count,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic signed [15:0] audio_sample,
  input  logic [3:0]  active_voices,
  input  logic [15:0] steal_count,
  output int          errors,
  output int          pending
);
  import psve_pkg::*;

  localparam int NV = 8;
  localparam int TBITS = 10;
  localparam int TSIZE = 1 << TBITS;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic [15:0] sample;
    logic [3:0]  active;
    logic [15:0] steals;
  } sample_beat_t;

  sample_beat_t samples_due[$];

  logic signed [15:0] sine_tab [TSIZE];
  logic [31:0] pitch_inc [128];
  logic [23:0] atk_step, rel_factor, rel_floor;
  stage_t      v_stage [NV];
  logic [6:0]  v_note  [NV];
  logic [31:0] v_phase [NV];
  logic [23:0] v_env   [NV];
  logic [6:0]  v_vel   [NV];
  logic [31:0] v_stamp [NV];
  logic [31:0] note_seq;
  logic [15:0] steal_total;

  function automatic longint quarter_wave(longint unsigned k, longint unsigned q);
    longint unsigned x, x2, term;
    longint sum;
    x = k * HALF_PI_Q30 / q;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    for (int j = 1; j <= 5; j++) begin
      term = ((term * x2) >> 30) / longint'((2 * j) * (2 * j + 1));
      if (j & 1) sum -= term;
      else sum += term;
    end
    if (sum < 0) sum = 0;
    sum = (sum + (1 << 14)) >>> 15;
    if (sum > 32767) sum = 32767;
    return sum;
  endfunction

  initial begin
    longint unsigned num, den, quarter, r;
    int qd;
    longint v;
    quarter = TSIZE / 4;
    for (int i = 0; i < TSIZE; i++) begin
      qd = i >> (TBITS - 2);
      r = i & (quarter - 1);
      v = (qd & 1) ? quarter_wave(quarter - r, quarter) : quarter_wave(r, quarter);
      sine_tab[i] = 16'((qd & 2) ? -v : v);
    end
    for (int n = 0; n < 128; n++) begin
      num = longint'(OCTAVE5_HZ_Q16[n % 12]) << (n / 12);
      num = num << 11;
      den = 48000;
      pitch_inc[n] = 32'((num + den / 2) / den);
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic start_note(input logic [6:0] pitch, input logic [6:0] vel);
    int pick;
    bit found;
    pick = 0;
    found = 1'b0;
    for (int i = 0; i < NV; i++)
      if (!found && v_stage[i] == STAGE_OFF) begin
        pick = i;
        found = 1'b1;
      end
    if (!found) begin
      for (int i = 1; i < NV; i++)
        if (v_stamp[i] < v_stamp[pick]) pick = i;
      if (steal_total != 16'hFFFF) steal_total++;
    end
    note_seq++;
    v_stage[pick] = STAGE_ATTACK;
    v_note[pick]  = pitch;
    v_stamp[pick] = note_seq;
    v_phase[pick] = '0;
    v_env[pick]   = '0;
    v_vel[pick]   = vel;
  endtask

  function automatic sample_beat_t mix_tick();
    sample_beat_t b;
    longint sum, mag;
    longint unsigned envl, lvl, prod, s_abs;
    int active;
    logic signed [15:0] s;
    sum = 0;
    active = 0;
    for (int i = 0; i < NV; i++) begin
      if (v_stage[i] == STAGE_OFF) continue;
      active++;
      envl = v_env[i];
      if (v_stage[i] == STAGE_ATTACK) begin
        envl += atk_step;
        if (envl >= ENV_ONE) begin
          envl = ENV_ONE;
          v_stage[i] = STAGE_SUSTAIN;
        end
      end else if (v_stage[i] == STAGE_RELEASE) begin
        envl = (envl * rel_factor) >> 24;
        if (envl < rel_floor) begin
          v_env[i] = envl[23:0];
          v_stage[i] = STAGE_OFF;
          continue;
        end
      end
      v_env[i] = envl[23:0];
      lvl = (longint'(v_vel[i]) * 786432 + 6350) / 12700;
      s = sine_tab[v_phase[i][31 -: TBITS]];
      s_abs = s < 0 ? -longint'(s) : longint'(s);
      prod = (s_abs * envl * lvl) >> 23;
      if (s < 0) sum -= prod;
      else sum += prod;
      v_phase[i] = v_phase[i] + pitch_inc[v_note[i]];
    end
    mag = sum < 0 ? -sum : sum;
    mag = (mag + 32768) >>> 16;
    if (mag > 40000) mag = 40000;
    if (sum < 0) mag = -mag;
    if (mag > 32767) mag = 32767;
    if (mag < -32768) mag = -32768;
    b.sample = mag[15:0];
    b.active = active > 15 ? 4'd15 : 4'(active);
    b.steals = steal_total;
    return b;
  endfunction

  always @(posedge clk) begin
    sample_beat_t want;
    logic [6:0] d1, d2;
    if (rst) begin
      atk_step   <= ATTACK_STEP_RST;
      rel_factor <= RELEASE_FACTOR_RST;
      rel_floor  <= RELEASE_FLOOR_RST;
      for (int i = 0; i < NV; i++) begin
        v_stage[i] = STAGE_OFF;
        v_note[i]  = '0;
        v_phase[i] = '0;
        v_env[i]   = '0;
        v_vel[i]   = '0;
        v_stamp[i] = '0;
      end
      note_seq = '0;
      steal_total = '0;
      samples_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_ATTACK_STEP:    atk_step   <= pwdata[23:0];
          REG_RELEASE_FACTOR: rel_factor <= pwdata[23:0];
          REG_RELEASE_FLOOR:  rel_floor  <= pwdata[23:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (samples_due.size() == 0) begin
          report_mismatch("unexpected sample beat", audio_sample, 0);
        end else begin
          want = samples_due.pop_front();
          if (audio_sample !== want.sample)
            report_mismatch("audio_sample", audio_sample, $signed(want.sample));
          if (active_voices !== want.active)
            report_mismatch("active_voices", active_voices, want.active);
          if (steal_count !== want.steals)
            report_mismatch("steal_count", steal_count, want.steals);
        end
      end
      if (in_valid && !in_stall) begin
        if (command) begin
          samples_due.push_back(mix_tick());
        end else if (byte_count != 0) begin
          d1 = byte_count > 1 ? note_number : 7'd0;
          d2 = byte_count > 2 ? velocity : 7'd0;
          if (status_byte[7:4] == KIND_NOTE_ON && d2 != 0) begin
            start_note(d1, d2);
          end else if (status_byte[7:4] == KIND_NOTE_OFF
                       || status_byte[7:4] == KIND_NOTE_ON) begin
            for (int i = 0; i < NV; i++)
              if (v_note[i] == d1
                  && (v_stage[i] == STAGE_ATTACK || v_stage[i] == STAGE_SUSTAIN))
                v_stage[i] = STAGE_RELEASE;
          end
        end
      end
    end
    pending = samples_due.size();
  end

  initial errors = 0;
endmodule

// ===== test/tb_top.sv =====
// Top of the polyphonic sine voice engine testbench: clock, reset, register
// writes, MIDI and tick stimulus and the verdict. Depends on psve_pkg,
// psve_checker and the engine itself.
`timescale 1ns / 1ps

module tb_top;
  import psve_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 0;
  logic        rst = 1;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 0;
  logic        in_stall;
  logic        command = 0;
  logic [7:0]  status_byte = 0;
  logic [6:0]  note_number = 0;
  logic [6:0]  velocity = 0;
  logic [1:0]  byte_count = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic signed [15:0] audio_sample;
  logic [3:0]  active_voices;
  logic [15:0] steal_count;
  int          errors, pending;
  int          quiet_cycles = 0;
  bit          sink_hold = 0;
  bit          calm = 0;

  always #5 clk = ~clk;

  polyphonic_sine_voice_engine DUT (.*);

  psve_checker checker_i (.*);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** polyphonic_sine_voice_engine: FAILED **");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold when asked, none when calm.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (sink_hold) begin
        out_stall <= 1;
        for (int i = 0; i < 400; i++) @(posedge clk);
        sink_hold = 0;
      end else if (!calm && $urandom_range(3) == 0) begin
        n = $urandom_range(16, 1);
        out_stall <= 1;
        repeat (n) @(posedge clk);
      end else begin
        out_stall <= 0;
        repeat ($urandom_range(20, 1)) @(posedge clk);
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send_beat(input logic cmd, input logic [7:0] st, input logic [6:0] nn,
                           input logic [6:0] vel, input logic [1:0] cnt);
    if (!calm && $urandom_range(5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(16, 1)) @(posedge clk);
    end
    in_valid <= 1; command <= cmd; status_byte <= st;
    note_number <= nn; velocity <= vel; byte_count <= cnt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic tick();
    send_beat(1'b1, 8'($urandom), 7'($urandom), 7'($urandom), 2'($urandom));
  endtask

  task automatic note_on(input logic [6:0] nn, input logic [6:0] vel);
    send_beat(1'b0, {KIND_NOTE_ON, 4'($urandom)}, nn, vel, 2'd3);
  endtask

  task automatic random_phase(input int count);
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 55) tick();
      else if (sel < 75)
        note_on(7'($urandom_range(127, 20)), 7'($urandom_range(127, 1)));
      else if (sel < 88)
        send_beat(1'b0, {($urandom_range(1) ? KIND_NOTE_OFF : KIND_NOTE_ON), 4'($urandom)},
                  7'($urandom_range(127, 20)), 7'd0, 2'd3);
      else send_beat(1'b0, 8'($urandom), 7'($urandom), 7'($urandom), 2'($urandom));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes, every message kind, short messages, ticks.
    note_on(7'd0, 7'd127);
    note_on(7'd127, 7'd1);
    tick(); tick();
    send_beat(1'b0, 8'h90, 7'd0, 7'd0, 2'd3);
    send_beat(1'b0, 8'h8F, 7'd127, 7'd55, 2'd3);
    send_beat(1'b0, 8'h90, 7'd60, 7'd100, 2'd2);
    send_beat(1'b0, 8'h90, 7'd60, 7'd100, 2'd1);
    send_beat(1'b0, 8'h9A, 7'd64, 7'd100, 2'd0);
    send_beat(1'b0, 8'hB3, 7'd64, 7'd100, 2'd3);
    send_beat(1'b0, 8'hFF, 7'h7F, 7'h7F, 2'd3);
    for (int i = 0; i < 9; i++) note_on(7'(60 + i), 7'(10 * i + 5));
    tick(); tick(); tick();
    drain();

    write_reg(REG_ATTACK_STEP, 32'hFFFF_FFFF);
    write_reg(REG_RELEASE_FACTOR, 32'd0);
    write_reg(REG_RELEASE_FLOOR, 32'd8388608);
    random_phase(300);
    drain();

    write_reg(REG_ATTACK_STEP, 32'd1);
    write_reg(REG_RELEASE_FACTOR, 32'hFFFFFF);
    write_reg(REG_RELEASE_FLOOR, 32'd0);
    random_phase(300);
    drain();

    write_reg(REG_ATTACK_STEP, 32'd800000);
    write_reg(REG_RELEASE_FACTOR, 32'd14000000);
    write_reg(REG_RELEASE_FLOOR, 32'd5000);
    sink_hold = 1;
    random_phase(600);
    drain();

    write_reg(REG_ATTACK_STEP, 32'(ATTACK_STEP_RST));
    write_reg(REG_RELEASE_FACTOR, 32'(RELEASE_FACTOR_RST));
    write_reg(REG_RELEASE_FLOOR, 32'(RELEASE_FLOOR_RST));
    random_phase(400);
    calm = 1;
    random_phase(250);
    drain();

    if (errors == 0) $display("** polyphonic_sine_voice_engine: PASSED **");
    else $display("** polyphonic_sine_voice_engine: FAILED **");
    $finish;
  end
endmodule
